FILE: hw/rtl/uci_pkg.sv
// Package for the unwind code interpreter: command, result and op codes,
// payload structs and the slot-count helper.
// No dependencies; every other file of the block uses it by scoped name.
`default_nettype none

package uci_pkg;

   localparam int unsigned NUM_GPRS = 16;
   localparam int unsigned REG_W    = $clog2(NUM_GPRS);

   // index of the stack pointer in the register file
   localparam logic [REG_W-1:0] RSP_INDEX = REG_W'(4);
   // register index that selects the instruction pointer
   localparam logic [4:0] RIP_INDEX = 5'd16;

   // prologue limit that lets every code apply
   localparam logic [8:0] LIMIT_ALL = 9'd256;

   // input commands
   localparam logic [2:0] CMD_LOAD_REG = 3'd0;
   localparam logic [2:0] CMD_BEGIN    = 3'd1;
   localparam logic [2:0] CMD_SLOT     = 3'd2;
   localparam logic [2:0] CMD_DATA     = 3'd3;
   localparam logic [2:0] CMD_FINISH   = 3'd4;
   localparam logic [2:0] CMD_READ_REG = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_READ     = 2'd0;
   localparam logic [1:0] KIND_FINISHED = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;
   localparam logic [1:0] KIND_REGVAL   = 2'd3;

   // result status
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_INFO = 2'd1;
   localparam logic [1:0] STAT_READ_BAD = 2'd2;
   localparam logic [1:0] STAT_SEQUENCE = 2'd3;

   // unwind ops
   localparam logic [3:0] OP_PUSH_NONVOL     = 4'd0;
   localparam logic [3:0] OP_ALLOC_LARGE     = 4'd1;
   localparam logic [3:0] OP_ALLOC_SMALL     = 4'd2;
   localparam logic [3:0] OP_SET_FPREG       = 4'd3;
   localparam logic [3:0] OP_SAVE_NONVOL     = 4'd4;
   localparam logic [3:0] OP_SAVE_NONVOL_FAR = 4'd5;
   localparam logic [3:0] OP_SAVE_XMM128     = 4'd8;
   localparam logic [3:0] OP_SAVE_XMM128_FAR = 4'd9;
   localparam logic [3:0] OP_PUSH_MACHFRAME  = 4'd10;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PUSH     = 3'd1,
      PH_SAVE     = 3'd2,
      PH_TRAP_RIP = 3'd3,
      PH_TRAP_RSP = 3'd4,
      PH_RET      = 3'd5,
      PH_CLOSED   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [4:0]  reg_index;
      logic [63:0] value;
      logic [2:0]  version;
      logic [7:0]  code_count;
      logic [3:0]  fp_reg;
      logic [3:0]  fp_off;
      logic        chained;
      logic [15:0] slot;
      logic        read_ok;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] word;
      logic [63:0] stack_pointer;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [REG_W-1:0] addr;
      logic [63:0]      data;
   } rf_write_type;

   typedef struct packed {
      logic        en;
      logic [63:0] data;
   } sp_write_type;

   // slots taken by one code, zero for an op that is not defined
   function automatic logic [1:0] op_slots(input logic [3:0] op, input logic [3:0] info);
      logic [1:0] n;
      n = 2'd0;
      unique case (op)
         OP_PUSH_NONVOL:     n = 2'd1;
         OP_ALLOC_LARGE:     n = (info == 4'd0) ? 2'd2 : 2'd3;
         OP_ALLOC_SMALL:     n = 2'd1;
         OP_SET_FPREG:       n = 2'd1;
         OP_SAVE_NONVOL:     n = 2'd2;
         OP_SAVE_NONVOL_FAR: n = 2'd3;
         OP_SAVE_XMM128:     n = 2'd2;
         OP_SAVE_XMM128_FAR: n = 2'd3;
         OP_PUSH_MACHFRAME:  n = 2'd1;
         default:            n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/uci_chan_if.sv
// Valid/ready channel carrying one payload struct per transaction.
// Depends on uci_pkg for the payload types chosen by the instantiating level.
`default_nettype none

interface uci_chan_if #(
   parameter type payload_type = uci_pkg::req_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/uci_regfile.sv
// Sixteen-entry 64-bit general register file with one general write port,
// a dedicated stack pointer write port and a fixed stack pointer tap.
// Depends on uci_pkg.
`default_nettype none

module uci_regfile (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [uci_pkg::REG_W-1:0]    rd_addr,
   output logic [63:0]                       rd_data,
   output logic [63:0]                       sp_data,
   input  wire uci_pkg::rf_write_type        wr,
   input  wire uci_pkg::sp_write_type        sp_wr
);

   logic [63:0] regs_ff [uci_pkg::NUM_GPRS];

   assign rd_data = regs_ff[rd_addr];
   assign sp_data = regs_ff[uci_pkg::RSP_INDEX];

   // the stack pointer port lands after the general port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < uci_pkg::NUM_GPRS; i++) begin
            regs_ff[i] <= 64'd0;
         end
      end else begin
         if (wr.en) begin
            regs_ff[wr.addr] <= wr.data;
         end
         if (sp_wr.en) begin
            regs_ff[uci_pkg::RSP_INDEX] <= sp_wr.data;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/unwind_code_interpreter.sv
// Top level of the x64 unwind code interpreter.
// Depends on uci_pkg, uci_chan_if and uci_regfile.
//
// Each request transaction (register load or read, begin of an unwind info,
// one 16-bit code slot, a memory data word, or finish) is taken into an input
// register and executed from there once the output register is free or being
// drained, and any response lands in the output register; a new transaction
// is accepted every cycle while the response channel does not stall.
// Memory is reached through the response channel: a read response carries the
// address, and the caller answers with a data transaction. Any known command
// other than data while a read is open is answered with a sequence error.
`default_nettype none

module unwind_code_interpreter #(
   parameter int unsigned MAX_CODE_SLOTS = 255
) (
   input  wire logic   clock,
   input  wire logic   reset,
   uci_chan_if.sink    req_chan,
   uci_chan_if.source  rsp_chan
);

   // input stage
   logic             in_valid_ff, in_valid_in;
   uci_pkg::req_type in_item_ff;
   // output stage
   logic             out_valid_ff, out_valid_in;
   uci_pkg::rsp_type out_item_ff, out_item_in;

   // interpreter state
   logic [63:0]         ip_ff, ip_in;
   logic [63:0]         fp_base_ff, fp_base_in;
   logic [8:0]          limit_ff, limit_in;
   logic [7:0]          slots_left_ff, slots_left_in;
   logic [3:0]          pend_op_ff, pend_op_in;
   logic [3:0]          pend_info_ff, pend_info_in;
   logic [1:0]          extra_ff, extra_in;
   logic [31:0]         accum_ff, accum_in;
   logic                skip_ff, skip_in;
   uci_pkg::phase_type  phase_ff, phase_in;
   logic [63:0]         trap_ff, trap_in;

   logic advance;
   logic req_fire;

   // register file access
   logic [uci_pkg::REG_W-1:0] rd_addr;
   logic [63:0]               rd_data;
   logic [63:0]               sp_rd;
   uci_pkg::rf_write_type     wr;
   uci_pkg::sp_write_type     sp_wr;

   // decode of the held transaction
   logic        pending;
   logic [7:0]  slot_offset;
   logic [3:0]  slot_op;
   logic [3:0]  slot_info;
   logic [1:0]  first_n;
   logic [1:0]  cont_n;
   logic [63:0] begin_offset;
   logic        bad_header;

   // code execution
   logic        do_exec;
   logic [3:0]  ex_op;
   logic [3:0]  ex_info;
   logic [63:0] ex_alloc;

   // response being formed
   logic        emit;
   logic [1:0]  emit_kind;
   logic [63:0] emit_word;
   logic [1:0]  emit_status;
   logic [63:0] sp_after;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

   assign rd_addr = (in_item_ff.cmd == uci_pkg::CMD_BEGIN) ? in_item_ff.fp_reg
                                                          : in_item_ff.reg_index[3:0];

   uci_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .sp_data (sp_rd),
      .wr      (wr),
      .sp_wr   (sp_wr)
   );

   assign pending = (phase_ff == uci_pkg::PH_PUSH) || (phase_ff == uci_pkg::PH_SAVE)
                 || (phase_ff == uci_pkg::PH_TRAP_RIP) || (phase_ff == uci_pkg::PH_TRAP_RSP)
                 || (phase_ff == uci_pkg::PH_RET);

   assign slot_offset  = in_item_ff.slot[7:0];
   assign slot_op      = in_item_ff.slot[11:8];
   assign slot_info    = in_item_ff.slot[15:12];
   assign first_n      = uci_pkg::op_slots(slot_op, slot_info);
   assign cont_n       = uci_pkg::op_slots(pend_op_ff, pend_info_ff);
   assign begin_offset = ip_ff - in_item_ff.value;
   assign bad_header   = !(in_item_ff.version == 3'd1 || in_item_ff.version == 3'd2)
                      || (in_item_ff.code_count > 8'(MAX_CODE_SLOTS));

   assign ex_alloc = (ex_info == 4'd0) ? {45'd0, accum_in[15:0], 3'd0} : {32'd0, accum_in};

   always_comb begin
      ip_in         = ip_ff;
      fp_base_in    = fp_base_ff;
      limit_in      = limit_ff;
      slots_left_in = slots_left_ff;
      pend_op_in    = pend_op_ff;
      pend_info_in  = pend_info_ff;
      extra_in      = extra_ff;
      accum_in      = accum_ff;
      skip_in       = skip_ff;
      phase_in      = phase_ff;
      trap_in       = trap_ff;
      wr            = '0;
      sp_wr         = '0;
      emit          = 1'b0;
      emit_kind     = uci_pkg::KIND_ERROR;
      emit_word     = 64'd0;
      emit_status   = uci_pkg::STAT_OK;
      do_exec       = 1'b0;
      ex_op         = pend_op_ff;
      ex_info       = pend_info_ff;

      if (in_item_ff.cmd > uci_pkg::CMD_READ_REG) begin
         // unknown command: drop silently
      end else if (pending) begin
         if (in_item_ff.cmd != uci_pkg::CMD_DATA) begin
            emit        = 1'b1;
            emit_status = uci_pkg::STAT_SEQUENCE;
         end else if (!in_item_ff.read_ok) begin
            slots_left_in = 8'd0;
            extra_in      = 2'd0;
            skip_in       = 1'b0;
            phase_in      = uci_pkg::PH_IDLE;
            emit          = 1'b1;
            emit_status   = uci_pkg::STAT_READ_BAD;
         end else begin
            unique case (phase_ff)
               uci_pkg::PH_PUSH: begin
                  wr.en      = 1'b1;
                  wr.addr    = pend_info_ff;
                  wr.data    = in_item_ff.value;
                  sp_wr.en   = 1'b1;
                  sp_wr.data = ((pend_info_ff == uci_pkg::RSP_INDEX) ? in_item_ff.value
                                                                     : sp_rd) + 64'd8;
                  phase_in   = uci_pkg::PH_IDLE;
               end
               uci_pkg::PH_SAVE: begin
                  wr.en    = 1'b1;
                  wr.addr  = pend_info_ff;
                  wr.data  = in_item_ff.value;
                  phase_in = uci_pkg::PH_IDLE;
               end
               uci_pkg::PH_TRAP_RIP: begin
                  trap_in   = in_item_ff.value;
                  phase_in  = uci_pkg::PH_TRAP_RSP;
                  emit      = 1'b1;
                  emit_kind = uci_pkg::KIND_READ;
                  emit_word = sp_rd + ((pend_info_ff != 4'd0) ? 64'd32 : 64'd24);
               end
               uci_pkg::PH_TRAP_RSP: begin
                  ip_in         = trap_ff;
                  sp_wr.en      = 1'b1;
                  sp_wr.data    = in_item_ff.value;
                  slots_left_in = 8'd0;
                  extra_in      = 2'd0;
                  phase_in      = uci_pkg::PH_CLOSED;
                  emit          = 1'b1;
                  emit_kind     = uci_pkg::KIND_FINISHED;
                  emit_word     = trap_ff;
               end
               default: begin
                  // return address pop
                  sp_wr.en   = 1'b1;
                  sp_wr.data = sp_rd + 64'd8;
                  ip_in      = in_item_ff.value;
                  phase_in   = uci_pkg::PH_IDLE;
                  emit       = 1'b1;
                  emit_kind  = uci_pkg::KIND_FINISHED;
                  emit_word  = in_item_ff.value;
               end
            endcase
         end
      end else begin
         unique case (in_item_ff.cmd)
            uci_pkg::CMD_LOAD_REG: begin
               if (in_item_ff.reg_index < uci_pkg::RIP_INDEX) begin
                  wr.en   = 1'b1;
                  wr.addr = in_item_ff.reg_index[3:0];
                  wr.data = in_item_ff.value;
               end else if (in_item_ff.reg_index == uci_pkg::RIP_INDEX) begin
                  ip_in = in_item_ff.value;
               end
            end
            uci_pkg::CMD_BEGIN: begin
               slots_left_in = 8'd0;
               extra_in      = 2'd0;
               skip_in       = 1'b0;
               phase_in      = uci_pkg::PH_IDLE;
               if (bad_header) begin
                  emit        = 1'b1;
                  emit_status = uci_pkg::STAT_BAD_INFO;
               end else begin
                  slots_left_in = in_item_ff.code_count;
                  fp_base_in    = (in_item_ff.fp_reg != 4'd0)
                                ? rd_data - {56'd0, in_item_ff.fp_off, 4'd0}
                                : sp_rd;
                  limit_in      = (in_item_ff.chained || begin_offset > 64'd255)
                                ? uci_pkg::LIMIT_ALL : begin_offset[8:0];
               end
            end
            uci_pkg::CMD_SLOT: begin
               if (slots_left_ff == 8'd0) begin
                  emit        = 1'b1;
                  emit_status = uci_pkg::STAT_SEQUENCE;
               end else if (extra_ff != 2'd0) begin
                  // operand slot of the open code
                  accum_in      = ({1'b0, extra_ff} + 3'd1 == {1'b0, cont_n})
                                ? {16'd0, in_item_ff.slot}
                                : accum_ff | {in_item_ff.slot, 16'd0};
                  extra_in      = extra_ff - 2'd1;
                  slots_left_in = slots_left_ff - 8'd1;
                  do_exec       = (extra_ff == 2'd1) && !skip_ff;
               end else if (first_n == 2'd0 || {6'd0, first_n} > slots_left_ff) begin
                  slots_left_in = 8'd0;
                  extra_in      = 2'd0;
                  skip_in       = 1'b0;
                  phase_in      = uci_pkg::PH_IDLE;
                  emit          = 1'b1;
                  emit_status   = uci_pkg::STAT_BAD_INFO;
               end else begin
                  slots_left_in = slots_left_ff - 8'd1;
                  pend_op_in    = slot_op;
                  pend_info_in  = slot_info;
                  extra_in      = first_n - 2'd1;
                  accum_in      = 32'd0;
                  skip_in       = {1'b0, slot_offset} > limit_ff;
                  ex_op         = slot_op;
                  ex_info       = slot_info;
                  do_exec       = (first_n == 2'd1) && !({1'b0, slot_offset} > limit_ff);
               end
            end
            uci_pkg::CMD_DATA: begin
               emit        = 1'b1;
               emit_status = uci_pkg::STAT_SEQUENCE;
            end
            uci_pkg::CMD_FINISH: begin
               emit = 1'b1;
               if (phase_ff == uci_pkg::PH_CLOSED) begin
                  emit_kind = uci_pkg::KIND_FINISHED;
                  emit_word = ip_ff;
               end else if (slots_left_ff != 8'd0) begin
                  emit_status = uci_pkg::STAT_SEQUENCE;
               end else begin
                  phase_in  = uci_pkg::PH_RET;
                  emit_kind = uci_pkg::KIND_READ;
                  emit_word = sp_rd;
               end
            end
            default: begin
               emit      = 1'b1;
               emit_kind = uci_pkg::KIND_REGVAL;
               if (in_item_ff.reg_index < uci_pkg::RIP_INDEX) begin
                  emit_word = rd_data;
               end else if (in_item_ff.reg_index == uci_pkg::RIP_INDEX) begin
                  emit_word = ip_ff;
               end
            end
         endcase

         if (do_exec) begin
            unique case (ex_op)
               uci_pkg::OP_PUSH_NONVOL: begin
                  phase_in  = uci_pkg::PH_PUSH;
                  emit      = 1'b1;
                  emit_kind = uci_pkg::KIND_READ;
                  emit_word = sp_rd;
               end
               uci_pkg::OP_ALLOC_LARGE: begin
                  sp_wr.en   = 1'b1;
                  sp_wr.data = sp_rd + ex_alloc;
               end
               uci_pkg::OP_ALLOC_SMALL: begin
                  sp_wr.en   = 1'b1;
                  sp_wr.data = sp_rd + {56'd0, ({1'b0, ex_info} + 5'd1), 3'd0};
               end
               uci_pkg::OP_SET_FPREG: begin
                  sp_wr.en   = 1'b1;
                  sp_wr.data = fp_base_ff;
               end
               uci_pkg::OP_SAVE_NONVOL: begin
                  phase_in  = uci_pkg::PH_SAVE;
                  emit      = 1'b1;
                  emit_kind = uci_pkg::KIND_READ;
                  emit_word = fp_base_ff + {45'd0, accum_in[15:0], 3'd0};
               end
               uci_pkg::OP_SAVE_NONVOL_FAR: begin
                  phase_in  = uci_pkg::PH_SAVE;
                  emit      = 1'b1;
                  emit_kind = uci_pkg::KIND_READ;
                  emit_word = fp_base_ff + {32'd0, accum_in};
               end
               uci_pkg::OP_PUSH_MACHFRAME: begin
                  phase_in  = uci_pkg::PH_TRAP_RIP;
                  emit      = 1'b1;
                  emit_kind = uci_pkg::KIND_READ;
                  emit_word = sp_rd + ((ex_info != 4'd0) ? 64'd8 : 64'd0);
               end
               default: begin
                  // xmm saves only consume their slots
               end
            endcase
         end
      end

      // hold the register file unless the transaction moves on
      if (!advance) begin
         wr.en    = 1'b0;
         sp_wr.en = 1'b0;
      end
   end

   // stack pointer as it stands after this transaction
   assign sp_after = sp_wr.en ? sp_wr.data
                   : ((wr.en && wr.addr == uci_pkg::RSP_INDEX) ? wr.data : sp_rd);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in              = emit;
         out_item_in.kind          = emit_kind;
         out_item_in.word          = emit_word;
         out_item_in.stack_pointer = sp_after;
         out_item_in.status        = emit_status;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_chan.payload;
      end
      out_item_ff <= out_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         ip_ff         <= 64'd0;
         fp_base_ff    <= 64'd0;
         limit_ff      <= 9'd0;
         slots_left_ff <= 8'd0;
         pend_op_ff    <= 4'd0;
         pend_info_ff  <= 4'd0;
         extra_ff      <= 2'd0;
         accum_ff      <= 32'd0;
         skip_ff       <= 1'b0;
         phase_ff      <= uci_pkg::PH_IDLE;
         trap_ff       <= 64'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ip_ff         <= ip_in;
            fp_base_ff    <= fp_base_in;
            limit_ff      <= limit_in;
            slots_left_ff <= slots_left_in;
            pend_op_ff    <= pend_op_in;
            pend_info_ff  <= pend_info_in;
            extra_ff      <= extra_in;
            accum_ff      <= accum_in;
            skip_ff       <= skip_in;
            phase_ff      <= phase_in;
            trap_ff       <= trap_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: bench/tb_unwind_code_interpreter.sv
// Testbench for unwind_code_interpreter: directed and random unwind sequences,
// with an internal mirror of the interpreter that predicts every response.
// Depends on uci_pkg, uci_chan_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_unwind_code_interpreter;

   localparam int RANDOM_ITEMS    = 950;
   localparam int CALM_FIRST      = 400;
   localparam int CALM_LAST       = 550;
   localparam int SQUEEZE_AFTER   = 150;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_CYCLES = 5000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_SLOTS       = 255;

   localparam logic [2:0] INFO_V1     = 3'd1;
   localparam logic [2:0] INFO_V2     = 3'd2;
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   localparam logic [3:0] OP_RESERVED = 4'd15;

   // Mirror of the interpreter state; holds the responses still owed.
   class unwind_mirror;
      logic [63:0]        gpr [uci_pkg::NUM_GPRS];
      logic [63:0]        rip;
      logic [63:0]        fp_base;
      logic [8:0]         limit;
      logic [7:0]         slots_left;
      logic [3:0]         pend_op;
      logic [3:0]         pend_info;
      logic [1:0]         extra_left;
      logic [31:0]        operand;
      bit                 skip;
      uci_pkg::phase_type phase;
      logic [63:0]        trap_addr;
      bit                 replied;
      uci_pkg::rsp_type   reply;
      uci_pkg::rsp_type   owed [$];
      int                 mismatches;

      function new();
         foreach (gpr[i]) gpr[i] = '0;
         rip        = '0;
         fp_base    = '0;
         limit      = '0;
         pend_op    = '0;
         pend_info  = '0;
         operand    = '0;
         trap_addr  = '0;
         mismatches = 0;
         close_info();
      endfunction

      function void close_info();
         slots_left = '0;
         extra_left = '0;
         skip       = 1'b0;
         phase      = uci_pkg::PH_IDLE;
      endfunction

      function bit read_open();
         return phase >= uci_pkg::PH_PUSH && phase <= uci_pkg::PH_RET;
      endfunction

      function int code_width(logic [3:0] op, logic [3:0] info);
         case (op)
            uci_pkg::OP_PUSH_NONVOL:     return 1;
            uci_pkg::OP_ALLOC_LARGE:     return (info == 4'd0) ? 2 : 3;
            uci_pkg::OP_ALLOC_SMALL:     return 1;
            uci_pkg::OP_SET_FPREG:       return 1;
            uci_pkg::OP_SAVE_NONVOL:     return 2;
            uci_pkg::OP_SAVE_NONVOL_FAR: return 3;
            uci_pkg::OP_SAVE_XMM128:     return 2;
            uci_pkg::OP_SAVE_XMM128_FAR: return 3;
            uci_pkg::OP_PUSH_MACHFRAME:  return 1;
            default:                     return 0;
         endcase
      endfunction

      function void answer(logic [1:0] kind, logic [63:0] word, logic [1:0] status);
         replied      = 1'b1;
         reply.kind   = kind;
         reply.word   = word;
         reply.status = status;
      endfunction

      function void run_code();
         case (pend_op)
            uci_pkg::OP_PUSH_NONVOL: begin
               phase = uci_pkg::PH_PUSH;
               answer(uci_pkg::KIND_READ, gpr[uci_pkg::RSP_INDEX], uci_pkg::STAT_OK);
            end
            uci_pkg::OP_ALLOC_LARGE: begin
               if (pend_info == 4'd0)
                  gpr[uci_pkg::RSP_INDEX] += 64'(operand[15:0]) << 3;
               else
                  gpr[uci_pkg::RSP_INDEX] += 64'(operand);
            end
            uci_pkg::OP_ALLOC_SMALL:
               gpr[uci_pkg::RSP_INDEX] += (64'(pend_info) + 64'd1) << 3;
            uci_pkg::OP_SET_FPREG:   gpr[uci_pkg::RSP_INDEX] = fp_base;
            uci_pkg::OP_SAVE_NONVOL: begin
               phase = uci_pkg::PH_SAVE;
               answer(uci_pkg::KIND_READ, fp_base + (64'(operand[15:0]) << 3),
                      uci_pkg::STAT_OK);
            end
            uci_pkg::OP_SAVE_NONVOL_FAR: begin
               phase = uci_pkg::PH_SAVE;
               answer(uci_pkg::KIND_READ, fp_base + 64'(operand), uci_pkg::STAT_OK);
            end
            uci_pkg::OP_PUSH_MACHFRAME: begin
               phase = uci_pkg::PH_TRAP_RIP;
               answer(uci_pkg::KIND_READ,
                      gpr[uci_pkg::RSP_INDEX] + ((pend_info != 4'd0) ? 64'd8 : 64'd0),
                      uci_pkg::STAT_OK);
            end
            default: ;
         endcase
      endfunction

      function void take_data(logic [63:0] value, logic ok);
         if (!ok) begin
            close_info();
            answer(uci_pkg::KIND_ERROR, '0, uci_pkg::STAT_READ_BAD);
            return;
         end
         case (phase)
            uci_pkg::PH_PUSH: begin
               gpr[pend_info] = value;
               gpr[uci_pkg::RSP_INDEX] += 64'd8;
               phase = uci_pkg::PH_IDLE;
            end
            uci_pkg::PH_SAVE: begin
               gpr[pend_info] = value;
               phase = uci_pkg::PH_IDLE;
            end
            uci_pkg::PH_TRAP_RIP: begin
               trap_addr = value;
               phase     = uci_pkg::PH_TRAP_RSP;
               answer(uci_pkg::KIND_READ, gpr[uci_pkg::RSP_INDEX]
                      + ((pend_info != 4'd0) ? 64'd8 : 64'd0) + 64'd24, uci_pkg::STAT_OK);
            end
            uci_pkg::PH_TRAP_RSP: begin
               rip                     = trap_addr;
               gpr[uci_pkg::RSP_INDEX] = value;
               slots_left              = '0;
               extra_left              = '0;
               phase                   = uci_pkg::PH_CLOSED;
               answer(uci_pkg::KIND_FINISHED, rip, uci_pkg::STAT_OK);
            end
            default: begin
               gpr[uci_pkg::RSP_INDEX] += 64'd8;
               rip   = value;
               phase = uci_pkg::PH_IDLE;
               answer(uci_pkg::KIND_FINISHED, rip, uci_pkg::STAT_OK);
            end
         endcase
      endfunction

      function void take_slot(logic [15:0] slot);
         int n;
         if (slots_left == 0) begin
            answer(uci_pkg::KIND_ERROR, '0, uci_pkg::STAT_SEQUENCE);
            return;
         end
         if (extra_left != 0) begin
            n = code_width(pend_op, pend_info);
            // first operand slot lands in the low half
            if (int'(extra_left) + 1 == n)
               operand = {16'd0, slot};
            else
               operand |= {slot, 16'd0};
            extra_left--;
            slots_left--;
            if (extra_left == 0 && !skip)
               run_code();
            return;
         end
         n = code_width(slot[11:8], slot[15:12]);
         if (n == 0 || n > int'(slots_left)) begin
            close_info();
            answer(uci_pkg::KIND_ERROR, '0, uci_pkg::STAT_BAD_INFO);
            return;
         end
         slots_left--;
         pend_op    = slot[11:8];
         pend_info  = slot[15:12];
         extra_left = 2'(n - 1);
         operand    = '0;
         skip       = {1'b0, slot[7:0]} > limit;
         if (n == 1 && !skip)
            run_code();
      endfunction

      function void open_info(uci_pkg::req_type r);
         logic [63:0] offset;
         offset = rip - r.value;
         close_info();
         if ((r.version != INFO_V1 && r.version != INFO_V2) || int'(r.code_count) > MAX_SLOTS)
         begin
            answer(uci_pkg::KIND_ERROR, '0, uci_pkg::STAT_BAD_INFO);
            return;
         end
         slots_left = r.code_count;
         if (r.fp_reg != 4'd0)
            fp_base = gpr[r.fp_reg] - (64'(r.fp_off) << 4);
         else
            fp_base = gpr[uci_pkg::RSP_INDEX];
         limit = (r.chained || offset > 64'd255) ? uci_pkg::LIMIT_ALL : offset[8:0];
      endfunction

      function void advance(uci_pkg::req_type r);
         if (r.cmd > uci_pkg::CMD_READ_REG)
            return;
         if (read_open()) begin
            if (r.cmd != uci_pkg::CMD_DATA)
               answer(uci_pkg::KIND_ERROR, '0, uci_pkg::STAT_SEQUENCE);
            else
               take_data(r.value, r.read_ok);
            return;
         end
         case (r.cmd)
            uci_pkg::CMD_LOAD_REG: begin
               if (r.reg_index < 5'd16)
                  gpr[r.reg_index[3:0]] = r.value;
               else if (r.reg_index == uci_pkg::RIP_INDEX)
                  rip = r.value;
            end
            uci_pkg::CMD_BEGIN: open_info(r);
            uci_pkg::CMD_SLOT:  take_slot(r.slot);
            uci_pkg::CMD_DATA:  answer(uci_pkg::KIND_ERROR, '0, uci_pkg::STAT_SEQUENCE);
            uci_pkg::CMD_FINISH: begin
               if (phase == uci_pkg::PH_CLOSED)
                  answer(uci_pkg::KIND_FINISHED, rip, uci_pkg::STAT_OK);
               else if (slots_left != 0)
                  answer(uci_pkg::KIND_ERROR, '0, uci_pkg::STAT_SEQUENCE);
               else begin
                  phase = uci_pkg::PH_RET;
                  answer(uci_pkg::KIND_READ, gpr[uci_pkg::RSP_INDEX], uci_pkg::STAT_OK);
               end
            end
            default: begin
               if (r.reg_index < 5'd16)
                  answer(uci_pkg::KIND_REGVAL, gpr[r.reg_index[3:0]], uci_pkg::STAT_OK);
               else if (r.reg_index == uci_pkg::RIP_INDEX)
                  answer(uci_pkg::KIND_REGVAL, rip, uci_pkg::STAT_OK);
               else
                  answer(uci_pkg::KIND_REGVAL, '0, uci_pkg::STAT_OK);
            end
         endcase
      endfunction

      function void note_request(uci_pkg::req_type r);
         replied = 1'b0;
         advance(r);
         if (replied) begin
            reply.stack_pointer = gpr[uci_pkg::RSP_INDEX];
            owed.push_back(reply);
         end
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(uci_pkg::rsp_type got);
         uci_pkg::rsp_type want;
         if (owed.size() == 0) begin
            $error("response with none outstanding: kind %0d word %h", got.kind, got.word);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         compare_field("kind", 64'(want.kind), 64'(got.kind));
         compare_field("word", want.word, got.word);
         compare_field("stack_pointer", want.stack_pointer, got.stack_pointer);
         compare_field("status", 64'(want.status), 64'(got.status));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;

   uci_chan_if #(.payload_type(uci_pkg::req_type)) req_if ();
   uci_chan_if #(.payload_type(uci_pkg::rsp_type)) rsp_if ();

   unwind_mirror mirror = new();

   unwind_code_interpreter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic uci_pkg::req_type fill(logic [2:0] cmd);
      uci_pkg::req_type item;
      item.cmd        = cmd;
      item.reg_index  = 5'($urandom);
      item.value      = {$urandom, $urandom};
      item.version    = 3'($urandom);
      item.code_count = 8'($urandom);
      item.fp_reg     = 4'($urandom);
      item.fp_off     = 4'($urandom);
      item.chained    = 1'($urandom);
      item.slot       = 16'($urandom);
      item.read_ok    = 1'($urandom);
      return item;
   endfunction

   function automatic uci_pkg::req_type reg_item(logic [2:0] cmd, logic [4:0] idx,
                                                 logic [63:0] value);
      uci_pkg::req_type item;
      item           = fill(cmd);
      item.reg_index = idx;
      item.value     = value;
      return item;
   endfunction

   function automatic uci_pkg::req_type info_begin(logic [2:0] version, logic [7:0] count,
                                                   logic [3:0] freg, logic [3:0] foff,
                                                   logic chained, logic [63:0] start);
      uci_pkg::req_type item;
      item            = fill(uci_pkg::CMD_BEGIN);
      item.version    = version;
      item.code_count = count;
      item.fp_reg     = freg;
      item.fp_off     = foff;
      item.chained    = chained;
      item.value      = start;
      return item;
   endfunction

   function automatic uci_pkg::req_type raw_slot(logic [15:0] slot);
      uci_pkg::req_type item;
      item      = fill(uci_pkg::CMD_SLOT);
      item.slot = slot;
      return item;
   endfunction

   function automatic uci_pkg::req_type code_slot(logic [3:0] op, logic [3:0] info,
                                                  logic [7:0] off);
      return raw_slot({info, op, off});
   endfunction

   function automatic uci_pkg::req_type data_item(logic ok, logic [63:0] value);
      uci_pkg::req_type item;
      item         = fill(uci_pkg::CMD_DATA);
      item.read_ok = ok;
      item.value   = value;
      return item;
   endfunction

   function automatic logic [4:0] pick_index();
      if ($urandom_range(99) < 8)
         return 5'($urandom_range(31, 17));
      return 5'($urandom_range(16, 0));
   endfunction

   function automatic uci_pkg::req_type start_info();
      uci_pkg::req_type item;
      int               roll;
      item = fill(uci_pkg::CMD_BEGIN);
      if ($urandom_range(99) < 90)
         item.version = $urandom_range(1) ? INFO_V2 : INFO_V1;
      roll = $urandom_range(99);
      if (roll < 2)
         item.code_count = 8'd255;
      else if (roll >= 6)
         item.code_count = 8'($urandom_range(8, 0));
      item.chained = $urandom_range(99) < 40;
      // keep the start near rip so that the prologue limit often bites
      if ($urandom_range(1))
         item.value = mirror.rip - 64'($urandom_range(300, 0));
      return item;
   endfunction

   // Next random transaction, shaped by where the mirror says the block is.
   function automatic uci_pkg::req_type pick_item();
      uci_pkg::req_type item;
      int               roll;
      int               width;
      bit               want_valid;
      bit               must_fit;
      item = fill(3'($urandom));
      roll = $urandom_range(99);
      if (mirror.read_open()) begin
         if (roll < 4)
            item.cmd = (roll < 2) ? uci_pkg::CMD_FINISH : uci_pkg::CMD_SLOT;
         else begin
            item.cmd     = uci_pkg::CMD_DATA;
            item.read_ok = roll >= 8;
         end
      end else if (mirror.slots_left != 0) begin
         if (roll < 2)
            item.cmd = uci_pkg::CMD_FINISH;
         else if (roll < 4)
            item = start_info();
         else begin
            item.cmd = uci_pkg::CMD_SLOT;
            if (mirror.extra_left == 0) begin
               want_valid = $urandom_range(99) >= 4;
               must_fit   = $urandom_range(99) >= 15;
               do begin
                  item.slot[11:8] = 4'($urandom);
                  width = mirror.code_width(item.slot[11:8], item.slot[15:12]);
               end while (want_valid &&
                          (width == 0 || (must_fit && width > int'(mirror.slots_left))));
            end
         end
      end else begin
         if (roll < 30)
            item = start_info();
         else if (roll < 45) begin
            item.cmd       = uci_pkg::CMD_LOAD_REG;
            item.reg_index = pick_index();
         end else if (roll < 60) begin
            item.cmd       = uci_pkg::CMD_READ_REG;
            item.reg_index = pick_index();
         end else if (roll < 88)
            item.cmd = uci_pkg::CMD_FINISH;
         else if (roll < 93)
            item.cmd = uci_pkg::CMD_DATA;
         else if (roll < 97)
            item.cmd = uci_pkg::CMD_SLOT;
         else
            item.cmd = $urandom_range(1) ? CMD_SPARE_B : CMD_SPARE_A;
      end
      return item;
   endfunction

   // Offer one transaction, hold it until taken, then log it with the mirror.
   task automatic send_item(input uci_pkg::req_type item);
      if (!no_idle && $urandom_range(99) < 30) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while (!no_idle && $urandom_range(99) < 30);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      mirror.note_request(item);
   endtask

   // Response side: check, then idle at random; one long hold-off to fill the block.
   initial begin
      int  responses_seen;
      int  hold_left;
      bit  squeezed;
      responses_seen = 0;
      hold_left      = 0;
      squeezed       = 1'b0;
      rsp_if.ready   = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            mirror.check_response(rsp_if.payload);
            responses_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!squeezed && responses_seen >= SQUEEZE_AFTER) begin
            squeezed  = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 30);
      end
   end

   // End the run if neither channel moves for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      wait (!reset);
      while (quiet_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      uci_pkg::req_type item;
      int               items_sent;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: range edges, sequence errors, push, large alloc, save and machine-frame codes, skip and failures
      send_item(reg_item(uci_pkg::CMD_READ_REG, 5'd31, '0));
      send_item(reg_item(uci_pkg::CMD_LOAD_REG, 5'd17, '1));
      send_item(reg_item(uci_pkg::CMD_LOAD_REG, uci_pkg::RIP_INDEX, 64'h1000));
      send_item(reg_item(uci_pkg::CMD_LOAD_REG, 5'(uci_pkg::RSP_INDEX),
                         64'h8000_0000_0000_0000));
      send_item(reg_item(uci_pkg::CMD_LOAD_REG, 5'd15, '1));
      send_item(info_begin(3'd0, 8'd3, 4'd0, 4'd0, 1'b0, '0));
      send_item(data_item(1'b1, '0));
      send_item(code_slot(uci_pkg::OP_PUSH_NONVOL, 4'd0, 8'd0));
      send_item(info_begin(INFO_V2, 8'd255, 4'd15, 4'd15, 1'b0, 64'h0ff0));
      send_item(code_slot(OP_RESERVED, 4'd0, 8'd0));
      send_item(info_begin(INFO_V1, 8'd1, 4'd0, 4'd0, 1'b1, '0));
      send_item(code_slot(uci_pkg::OP_SAVE_NONVOL, 4'd3, 8'd0));
      send_item(info_begin(INFO_V1, 8'd8, 4'd0, 4'd0, 1'b1, '0));
      send_item(code_slot(uci_pkg::OP_PUSH_NONVOL, 4'd3, 8'hff));
      send_item(fill(uci_pkg::CMD_FINISH));
      send_item(data_item(1'b1, 64'h0123_4567_89ab_cdef));
      send_item(code_slot(uci_pkg::OP_ALLOC_LARGE, 4'd1, 8'hff));
      send_item(raw_slot(16'hffff));
      send_item(raw_slot(16'hffff));
      send_item(code_slot(uci_pkg::OP_PUSH_MACHFRAME, 4'd1, 8'd0));
      send_item(data_item(1'b1, 64'h2000));
      send_item(data_item(1'b1, 64'h7fff_fff0));
      send_item(fill(uci_pkg::CMD_FINISH));
      send_item(info_begin(INFO_V1, 8'd3, 4'd0, 4'd0, 1'b0, 64'h2000));
      send_item(code_slot(uci_pkg::OP_SAVE_NONVOL_FAR, 4'd2, 8'd5));
      send_item(raw_slot(16'h0000));
      send_item(raw_slot(16'hffff));
      send_item(fill(uci_pkg::CMD_FINISH));
      send_item(data_item(1'b0, '1));
      send_item(fill(CMD_SPARE_B));

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         no_idle = items_sent >= CALM_FIRST && items_sent < CALM_LAST;
         item = pick_item();
         send_item(item);
         if (item.cmd <= uci_pkg::CMD_READ_REG)
            items_sent++;
      end
      req_if.valid <= 1'b0;

      // drain: wait for every owed response, then watch for strays
      while (mirror.owed.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.owed.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
